>>> rtl/core/qmap_pkg.sv
// qmap_pkg: shared types and constants of the qmap deaggregator
// used by qmap_parser and qmap_deaggregator, no dependencies
package qmap_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned PAD_W     = 6;
    localparam int unsigned HCNT_W    = 3;

    localparam logic [BYTE_W-1:0] PAD_MASK    = 8'h3f;
    localparam logic [HCNT_W-1:0] HDR_LAST_V4 = 3'd3;
    localparam logic [HCNT_W-1:0] HDR_LAST_V9 = 3'd7;

    // header byte positions
    localparam logic [HCNT_W-1:0] HB_PAD     = 3'd0;
    localparam logic [HCNT_W-1:0] HB_MUX     = 3'd1;
    localparam logic [HCNT_W-1:0] HB_LEN_HI  = 3'd2;
    localparam logic [HCNT_W-1:0] HB_LEN_LO  = 3'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] channel_id;
        logic              packet_end;
        logic              truncated;
    } qmap_result_t;

endpackage

>>> rtl/core/qmap_parser.sv
// qmap_parser: per-byte header/payload/pad state and result decode
// depends on qmap_pkg
module qmap_parser
    import qmap_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_eot,
    input  logic              mode_v9,
    output logic              res_valid,
    output qmap_result_t      res
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_PAD     = 2'd2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [HCNT_W-1:0] byte_count_reg, byte_count_next;
    logic [LEN_W-1:0]  payload_left_reg, payload_left_next;
    logic [PAD_W-1:0]  pad_left_reg, pad_left_next;
    logic [BYTE_W-1:0] channel_reg, channel_next;
    logic [BYTE_W-1:0] length_high_reg, length_high_next;

    logic [HCNT_W-1:0] hdr_last;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pay_dec;
    logic [PAD_W-1:0]  pad;
    logic              last;
    logic              trunc;

    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        payload_left_next = payload_left_reg;
        pad_left_next     = pad_left_reg;
        channel_next      = channel_reg;
        length_high_next  = length_high_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.channel_id    = channel_reg;

        hdr_last = mode_v9 ? HDR_LAST_V9 : HDR_LAST_V4;
        len      = (byte_count_reg == HB_LEN_LO) ? {length_high_reg, in_byte}
                                                 : payload_left_reg;
        pad      = (byte_count_reg == HB_PAD) ? PAD_W'(in_byte & PAD_MASK) : pad_left_reg;
        pay_dec  = payload_left_reg - LEN_W'(1);
        last     = (payload_left_reg <= LEN_W'(1));
        trunc    = in_eot && !last;

        case (phase_reg)
            PH_PAYLOAD: begin
                res_valid         = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = in_byte;
                res.packet_end    = last || trunc;
                res.truncated     = trunc;
                payload_left_next = pay_dec;
                if (pay_dec == '0) begin
                    phase_next = (pad_left_reg != '0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_PAD: begin
                pad_left_next = pad_left_reg - PAD_W'(1);
                if (pad_left_next == '0) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                // header phase, unused code lands here too
                phase_next = PH_HEADER;
                case (byte_count_reg)
                    HB_PAD:    pad_left_next     = pad;
                    HB_MUX:    channel_next      = in_byte;
                    HB_LEN_HI: length_high_next  = in_byte;
                    HB_LEN_LO: payload_left_next = len;
                    default:   ;
                endcase
                if (byte_count_reg >= hdr_last) begin
                    byte_count_next = '0;
                    if ({{(LEN_W-PAD_W){1'b0}}, pad} > len) begin
                        // pad larger than length: report and skip length bytes
                        res_valid         = 1'b1;
                        res.kind          = KIND_DROP;
                        pad_left_next     = len[PAD_W-1:0];
                        payload_left_next = '0;
                        phase_next        = (len[PAD_W-1:0] != '0) ? PH_PAD : PH_HEADER;
                    end else begin
                        payload_left_next = len - {{(LEN_W-PAD_W){1'b0}}, pad};
                        if (payload_left_next != '0) begin
                            phase_next = PH_PAYLOAD;
                        end else begin
                            phase_next = (pad != '0) ? PH_PAD : PH_HEADER;
                        end
                    end
                end else begin
                    byte_count_next = byte_count_reg + HCNT_W'(1);
                end
            end
        endcase

        if (in_eot) begin
            phase_next        = PH_HEADER;
            byte_count_next   = '0;
            payload_left_next = '0;
            pad_left_next     = '0;
            channel_next      = '0;
            length_high_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            byte_count_reg   <= '0;
            payload_left_reg <= '0;
            pad_left_reg     <= '0;
            channel_reg      <= '0;
            length_high_reg  <= '0;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            payload_left_reg <= payload_left_next;
            pad_left_reg     <= pad_left_next;
            channel_reg      <= channel_next;
            length_high_reg  <= length_high_next;
        end
    end

`ifndef SYNTHESIS
    a_pad_phase_has_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAD |-> pad_left_reg != '0)
        else $error("pad phase with zero pad count");

    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_eot |=> phase_reg == PH_HEADER && byte_count_reg == '0)
        else $error("state not cleared after end of transfer");

    a_drop_only_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind == KIND_DROP |-> phase_reg != PH_PAYLOAD
            && phase_reg != PH_PAD)
        else $error("drop reported outside header phase");
`endif

endmodule

>>> rtl/core/qmap_deaggregator.sv
// qmap_deaggregator: top level, config register, parser and result register
// depends on qmap_pkg and qmap_parser
//
// Usage:
//   s_* channel takes one byte of an aggregated transfer per item, with
//   s_end_of_transfer high on the final byte. m_* channel gives at most one
//   result item per input item: a payload byte tagged with the mux id and
//   end/truncated flags, or a drop report (m_kind 1) when pad exceeds length.
//   cfg_* channel writes header_mode_v9 (1: 8-byte headers, 0: 4-byte);
//   cfg_ready is always high, write only while the block is idle.
// Timing and throughput:
//   a result appears on m_* in the cycle after its input byte is accepted.
//   One byte per cycle sustained while m_ready is high; parser state and the result register
//   update in the same cycle, so the pace is set by the output register.
// Stall:
//   while m_valid is high and m_ready low, s_ready drops; when m_ready is
//   high a new byte is taken in the same cycle the held result leaves.
// Reset:
//   aresetn low (synchronous) clears the parser to header phase, clears
//   header_mode_v9 and empties the result register. No clearing pass.
module qmap_deaggregator
    import qmap_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_end_of_transfer,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [BYTE_W-1:0] m_payload_byte,
    output logic [BYTE_W-1:0] m_channel_id,
    output logic              m_packet_end,
    output logic              m_truncated
);

    logic         mode_v9_reg;
    logic         m_valid_reg, m_valid_next;
    qmap_result_t out_reg;
    logic         in_accept;
    logic         res_valid;
    qmap_result_t res;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    qmap_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_in_byte),
        .in_eot    (s_end_of_transfer),
        .mode_v9   (mode_v9_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_accept) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_v9_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_v9_reg <= cfg_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_channel_id   = out_reg.channel_id;
    assign m_packet_end   = out_reg.packet_end;
    assign m_truncated    = out_reg.truncated;

`ifndef SYNTHESIS
    a_drop_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DROP |->
            m_payload_byte == '0 && !m_packet_end && !m_truncated)
        else $error("drop item carries payload fields");

    a_trunc_ends_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_packet_end)
        else $error("truncated item without packet end");

    a_held_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(out_reg))
        else $error("stalled result lost or changed");
`endif

endmodule

>>> verif/qmap_deaggr_monitor.sv
// qmap_deaggr_monitor: watches the config, byte and result channels of qmap_deaggregator,
// predicts each result item from the accepted bytes and compares it; depends on qmap_pkg
module qmap_deaggr_monitor
    import qmap_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_end_of_transfer,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_kind,
    input  logic [BYTE_W-1:0] m_payload_byte,
    input  logic [BYTE_W-1:0] m_channel_id,
    input  logic              m_packet_end,
    input  logic              m_truncated,
    output int unsigned       mismatches,
    output int unsigned       pending,
    output int unsigned       results_seen,
    output int unsigned       drops_seen,
    output int unsigned       cut_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        ST_HDR  = 2'd0,
        ST_DATA = 2'd1,
        ST_SKIP = 2'd2
    } parse_state_t;

    parse_state_t      state;
    logic [LEN_W-1:0]  hdr_idx;
    logic [LEN_W-1:0]  bytes_due;
    logic [PAD_W-1:0]  skip_left;
    logic [BYTE_W-1:0] mux_id;
    logic [BYTE_W-1:0] len_hi;
    logic              v9_mode;
    qmap_result_t      due_results[$];

    task automatic clear_parse();
        state     = ST_HDR;
        hdr_idx   = '0;
        bytes_due = '0;
        skip_left = '0;
        mux_id    = '0;
        len_hi    = '0;
    endtask

    // bytes_due holds the header length here
    task automatic close_header();
        logic [LEN_W-1:0] len;
        qmap_result_t     res;
        len     = bytes_due;
        hdr_idx = '0;
        if (LEN_W'(skip_left) > len) begin
            res.kind         = KIND_DROP;
            res.payload_byte = '0;
            res.channel_id   = mux_id;
            res.packet_end   = 1'b0;
            res.truncated    = 1'b0;
            due_results.push_back(res);
            skip_left = PAD_W'(len & LEN_W'(PAD_MASK));
            bytes_due = '0;
            state     = (skip_left != '0) ? ST_SKIP : ST_HDR;
        end else begin
            bytes_due = len - LEN_W'(skip_left);
            if (bytes_due != '0)
                state = ST_DATA;
            else
                state = (skip_left != '0) ? ST_SKIP : ST_HDR;
        end
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic eot);
        logic [LEN_W-1:0] hdr_end;
        logic             last;
        logic             cut;
        qmap_result_t     res;
        hdr_end = LEN_W'(v9_mode ? HDR_LAST_V9 : HDR_LAST_V4);
        case (state)
            ST_DATA: begin
                last = (bytes_due <= 1);
                cut  = eot && !last;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = b;
                res.channel_id   = mux_id;
                res.packet_end   = last | cut;
                res.truncated    = cut;
                due_results.push_back(res);
                bytes_due = bytes_due - 1'b1;
                if (bytes_due == '0)
                    state = (skip_left != '0) ? ST_SKIP : ST_HDR;
            end
            ST_SKIP: begin
                skip_left = skip_left - 1'b1;
                if (skip_left == '0)
                    state = ST_HDR;
            end
            default: begin
                state = ST_HDR;
                if (hdr_idx == LEN_W'(HB_PAD))
                    skip_left = PAD_W'(b & PAD_MASK);
                else if (hdr_idx == LEN_W'(HB_MUX))
                    mux_id = b;
                else if (hdr_idx == LEN_W'(HB_LEN_HI))
                    len_hi = b;
                else if (hdr_idx == LEN_W'(HB_LEN_LO))
                    bytes_due = {len_hi, b};
                // also closes a header that a mode change left past its end
                if (hdr_idx >= hdr_end)
                    close_header();
                else
                    hdr_idx = hdr_idx + 1'b1;
            end
        endcase
        if (eot)
            clear_parse();
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        qmap_result_t want;
        if (!aresetn) begin
            v9_mode = 1'b0;
            clear_parse();
            due_results.delete();
            mismatches   = 0;
            results_seen = 0;
            drops_seen   = 0;
            cut_seen     = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_kind == KIND_DROP)
                    drops_seen++;
                if (m_truncated)
                    cut_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $error("result item with nothing expected: kind %0h byte 0x%0h ch 0x%0h",
                           m_kind, m_payload_byte, m_channel_id);
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("payload_byte", want.payload_byte, m_payload_byte);
                    check_field("channel_id", want.channel_id, m_channel_id);
                    check_field("packet_end", want.packet_end, m_packet_end);
                    check_field("truncated", want.truncated, m_truncated);
                end
            end
            if (cfg_valid && cfg_ready)
                v9_mode = cfg_data;
            if (s_valid && s_ready)
                parse_byte(s_in_byte, s_end_of_transfer);
        end
        pending = due_results.size();
    end

endmodule

>>> verif/testbench.sv
// testbench: top level for qmap_deaggregator, drives bytes, config writes and result stalls
// depends on qmap_pkg, qmap_deaggregator and qmap_deaggr_monitor
module testbench;
    import qmap_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RAND_ITEMS = 1300;
    localparam int unsigned TIMEOUT_NS = 4_000_000;

    typedef enum int unsigned {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_style_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_in_byte;
    logic              s_end_of_transfer;
    logic              m_valid;
    logic              m_ready;
    logic              m_kind;
    logic [BYTE_W-1:0] m_payload_byte;
    logic [BYTE_W-1:0] m_channel_id;
    logic              m_packet_end;
    logic              m_truncated;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results_seen;
    int unsigned drops_seen;
    int unsigned cut_seen;

    int unsigned burst_left;
    int unsigned bytes_sent;
    int unsigned xfers_sent;
    int unsigned mode_writes;
    logic        cur_v9;

    qmap_deaggregator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_end_of_transfer (s_end_of_transfer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_payload_byte    (m_payload_byte),
        .m_channel_id      (m_channel_id),
        .m_packet_end      (m_packet_end),
        .m_truncated       (m_truncated)
    );

    qmap_deaggr_monitor u_monitor (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_end_of_transfer (s_end_of_transfer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_payload_byte    (m_payload_byte),
        .m_channel_id      (m_channel_id),
        .m_packet_end      (m_packet_end),
        .m_truncated       (m_truncated),
        .mismatches        (mismatches),
        .pending           (pending),
        .results_seen      (results_seen),
        .drops_seen        (drops_seen),
        .cut_seen          (cut_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    // receiver stalls in stretches of a random style
    initial begin
        rx_style_t   style;
        int unsigned span;
        m_ready <= 1'b0;
        forever begin
            style = rx_style_t'($urandom_range(0, 3));
            span  = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge aclk);
                case (style)
                    RX_OPEN:  m_ready <= 1'b1;
                    RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:  m_ready <= ($urandom_range(0, 1) != 0);
                    default:  m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // one item on the byte channel; the sender sometimes idles between bursts
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_in_byte         <= b;
        s_end_of_transfer <= eot;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        bytes_sent++;
        if (eot)
            xfers_sent++;
    endtask

    // v9 headers get four extra bytes after the length
    task automatic send_header(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] mux,
                               input logic [LEN_W-1:0] len, input logic eot_last);
        send_byte(b0, 1'b0);
        send_byte(mux, 1'b0);
        send_byte(len[15:8], 1'b0);
        send_byte(len[7:0], eot_last && !cur_v9);
        if (cur_v9) begin
            for (int i = 0; i < 4; i++)
                send_byte(8'($urandom), eot_last && i == 3);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        // a header byte gives no result, leave room for it to settle
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic v9);
        cfg_valid <= 1'b1;
        cfg_data  <= v9;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_v9 = v9;
        mode_writes++;
    endtask

    task automatic send_transfer();
        logic [BYTE_W-1:0] xfer[$];
        int unsigned       pkts;
        int unsigned       pad;
        int unsigned       len;
        int unsigned       body;
        int unsigned       cut;
        logic              long_pkt;
        pkts = $urandom_range(1, 4);
        for (int p = 0; p < pkts; p++) begin
            pad      = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
            long_pkt = 1'b0;
            case ($urandom_range(0, 9))
                0: len = $urandom_range(0, pad);
                1: begin
                    len      = $urandom_range(64, 65535);
                    long_pkt = 1'b1;
                end
                default: len = pad + $urandom_range(0, 12);
            endcase
            xfer.push_back({2'($urandom), 6'(pad)});
            xfer.push_back(8'($urandom));
            xfer.push_back(8'(len >> 8));
            xfer.push_back(8'(len));
            if (cur_v9)
                repeat (4) xfer.push_back(8'($urandom));
            // a dropped packet skips exactly its length, so the body is len bytes unless the packet is long
            body = long_pkt ? $urandom_range(1, 20) : len;
            repeat (body) xfer.push_back(8'($urandom));
            if (long_pkt)
                break;
        end
        case ($urandom_range(0, 11))
            0: begin
                if (xfer.size() > 1) begin
                    cut = $urandom_range(1, xfer.size() - 1);
                    repeat (cut) void'(xfer.pop_back());
                end
            end
            1: repeat ($urandom_range(1, 6)) xfer.push_back(8'($urandom));
            default: ;
        endcase
        for (int i = 0; i < xfer.size(); i++)
            send_byte(xfer[i], i == xfer.size() - 1);
    endtask

    initial begin
        int unsigned rand_goal;
        int unsigned phase_end;
        s_valid           <= 1'b0;
        s_in_byte         <= '0;
        s_end_of_transfer <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_data          <= 1'b0;
        aresetn           <= 1'b0;
        burst_left  = 0;
        bytes_sent  = 0;
        xfers_sent  = 0;
        mode_writes = 0;
        cur_v9      = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 4-byte headers: plain packet with extreme data
        send_header(8'h00, 8'hab, 16'd2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        // zero-length payload, pad skipped
        send_header(8'h02, 8'h22, 16'd2, 1'b0);
        send_byte(8'h3c, 1'b0);
        send_byte(8'hc3, 1'b0);
        // pad exceeds length on the header that ends the transfer
        send_header(8'hc5, 8'h11, 16'd3, 1'b1);
        // largest length, payload cut short
        send_header(8'h00, 8'h33, 16'hffff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b1);
        // header ends the transfer, payload lost
        send_header(8'h00, 8'h01, 16'd5, 1'b1);
        wait_idle();

        // 8-byte headers: payload with pad, then a header cut short
        write_mode(1'b1);
        send_header(8'h01, 8'hfe, 16'd2, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h44, 1'b1);
        // leave a header half done, then shorten the header length under it
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h99, 1'b0);
        wait_idle();
        write_mode(1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'he1, 1'b1);
        wait_idle();

        rand_goal = bytes_sent + RAND_ITEMS;
        while (bytes_sent < rand_goal) begin
            write_mode(!cur_v9);
            phase_end = bytes_sent + $urandom_range(150, 350);
            while (bytes_sent < phase_end && bytes_sent < rand_goal)
                send_transfer();
            wait_idle();
        end

        $display("sent %0d bytes in %0d transfers over %0d mode writes", bytes_sent,
                 xfers_sent, mode_writes);
        $display("checked %0d result items: %0d drop reports, %0d truncated payloads",
                 results_seen, drops_seen, cut_seen);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
